FILE: rtl/utf8_to_utf16_decoder_assert.svh
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define U8U16_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8_to_utf16_decoder check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define U8U16_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8_to_utf16_decoder check failed");

`endif

FILE: rtl/u8u16_pkg.sv
package u8u16_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  localparam int CONT_BITS = 6;
  localparam int CP_W      = 21;
  localparam int UNIT_W    = 16;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              beyond_bmp;
    logic              last;
  } unit_t;

  typedef struct packed {
    logic  push;
    unit_t unit;
  } front_req_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       beyond_bmp;
    logic       last;
  } out_t;

endpackage

FILE: rtl/utf8_to_utf16_decoder.sv
// UTF-8 byte stream to 16-bit code units. One byte is taken per cycle while
// in_full is low; each completed sequence of one to four bytes yields one
// result holding the code unit as two bytes (order set by cfg_wdata, 1 = high
// byte first), a flag for code points above 0xFFFF (cut to 16 bits) and the
// end-of-buffer mark of its final byte. Stray continuation bytes give nothing,
// and a partial sequence ending a buffer is discarded. A result passes from the
// decode stage into a QUEUE_DEPTH-entry queue and then into the output register
// that drives the out_ ports; with QUEUE_DEPTH of at least 2, full rises only
// when that queue and the output register both hold unread results.
module utf8_to_utf16_decoder #(
  parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  u8u16_pkg::in_t  in_data,
  output logic            out_empty,
  input  logic            out_pop,
  output u8u16_pkg::out_t out_data,
  input  logic            cfg_we,
  input  logic            cfg_wdata
);

  u8u16_pkg::front_req_t req;
  u8u16_pkg::unit_t      q_head;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;

  u8u16_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .req     (req)
  );

  u8u16_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .head      (q_head)
  );

  u8u16_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data)
  );

  assign in_full = q_full;

endmodule

FILE: rtl/u8u16_front.sv
module u8u16_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  u8u16_pkg::in_t         in_data,
  input  logic                   q_full,
  output u8u16_pkg::front_req_t  req
);

  logic [1:0]                 bytes_seen_r, bytes_seen_nxt;
  logic [2:0]                 seq_len_r, seq_len_nxt;
  logic [u8u16_pkg::CP_W-1:0] acc_r, acc_nxt;

  logic                       xfer;
  logic                       drop;
  logic                       complete;
  logic [2:0]                 seen;
  logic [2:0]                 len;
  logic [u8u16_pkg::CP_W-1:0] acc;
  logic [3:0]                 nib;

  assign xfer = in_push && !q_full;
  assign nib  = in_data.in_byte[7:4];
  assign seen = {1'b0, bytes_seen_r} + 3'd1;

  always_comb begin
    drop = 1'b0;
    len  = seq_len_r;
    acc  = {acc_r[u8u16_pkg::CP_W-u8u16_pkg::CONT_BITS-1:0],
            in_data.in_byte[u8u16_pkg::CONT_BITS-1:0]};
    if (bytes_seen_r == 2'd0) begin
      case (nib) inside
        [4'd0:4'd7]: begin
          len = u8u16_pkg::LEN_1;
          acc = {14'd0, in_data.in_byte[6:0]};
        end
        [4'd12:4'd13]: begin
          len = u8u16_pkg::LEN_2;
          acc = {16'd0, in_data.in_byte[4:0]};
        end
        4'd14: begin
          len = u8u16_pkg::LEN_3;
          acc = {17'd0, in_data.in_byte[3:0]};
        end
        4'd15: begin
          len = u8u16_pkg::LEN_4;
          acc = {18'd0, in_data.in_byte[2:0]};
        end
        default: begin
          drop = 1'b1;
        end
      endcase
    end
  end

  assign complete = !drop && (seen >= len);

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    seq_len_nxt    = seq_len_r;
    acc_nxt        = acc_r;
    if (xfer) begin
      if (drop || complete || in_data.end_of_buffer) begin
        bytes_seen_nxt = 2'd0;
        seq_len_nxt    = 3'd0;
        acc_nxt        = '0;
      end else begin
        bytes_seen_nxt = seen[1:0];
        seq_len_nxt    = len;
        acc_nxt        = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= 2'd0;
      seq_len_r    <= 3'd0;
      acc_r        <= '0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      seq_len_r    <= seq_len_nxt;
      acc_r        <= acc_nxt;
    end
  end

  assign req.push            = xfer && complete;
  assign req.unit.code_unit  = acc[u8u16_pkg::UNIT_W-1:0];
  assign req.unit.beyond_bmp = |acc[u8u16_pkg::CP_W-1:u8u16_pkg::UNIT_W];
  assign req.unit.last       = in_data.end_of_buffer;

endmodule

FILE: rtl/u8u16_fifo.sv
module u8u16_fifo #(
  parameter int Depth = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  u8u16_pkg::front_req_t req,
  output logic                  full,
  output logic                  not_empty,
  input  logic                  pop,
  output u8u16_pkg::unit_t      head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  u8u16_pkg::unit_t mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == CntFull);
  assign not_empty = (cnt_r != '0);
  assign do_push   = req.push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= req.unit;
    end
  end

endmodule

FILE: rtl/u8u16_back.sv
module u8u16_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              q_not_empty,
  input  u8u16_pkg::unit_t  q_head,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output u8u16_pkg::out_t   out_data
);

  logic            big_endian_r;
  logic            valid_r, valid_nxt;
  u8u16_pkg::out_t data_r, data_nxt;
  logic            load;

  assign load  = q_not_empty && (!valid_r || out_pop);
  assign q_pop = load;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_comb begin
    data_nxt            = data_r;
    data_nxt.beyond_bmp = q_head.beyond_bmp;
    data_nxt.last       = q_head.last;
    if (big_endian_r) begin
      data_nxt.first_byte  = q_head.code_unit[15:8];
      data_nxt.second_byte = q_head.code_unit[7:0];
    end else begin
      data_nxt.first_byte  = q_head.code_unit[7:0];
      data_nxt.second_byte = q_head.code_unit[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b1;
      valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        big_endian_r <= cfg_wdata;
      end
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_empty = !valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/u8u16_checker.sv
`include "utf8_to_utf16_decoder_assert.svh"

module u8u16_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_push,
  input logic            in_full,
  input logic            out_empty,
  input logic            out_pop,
  input u8u16_pkg::out_t out_data
);

  logic in_xfer;

  assign in_xfer = in_push && !in_full;

  // back-pressure only once the output register holds a result
  `U8U16_ASSERT_NOW(a_full_implies_result, in_full, !out_empty)

  // with no transfer in in_xfer or its $past value, nothing can surface from the queue
  `U8U16_ASSERT_NXT(a_no_phantom_result, out_empty && !in_xfer && !$past(in_xfer), out_empty)

  // unread result holds
  `U8U16_ASSERT_NXT(a_result_holds, !out_empty && !out_pop, !out_empty && $stable(out_data))

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
